### rtl/core/dpm_pkg.sv
// shared constants and helpers for the magnus dew point pipeline
// no dependencies
`timescale 1ns / 1ps

package dpm_pkg;

  localparam int          FRACTION_BITS_DEF = 16;
  localparam int          LOG_STEPS         = 28;
  localparam int          LOG_XW            = 31;
  localparam int          TEMP_W            = 11;
  localparam int          HUM_W             = 10;
  localparam int          DEW_W             = 11;
  localparam int          DEW_QW            = 12;
  localparam int          B_TENTHS          = 2377;
  localparam logic [29:0] LN2_Q30           = 30'd744261118;
  localparam int          DEW_LOW           = -900;
  localparam int          DEW_HIGH          = 800;

  // log2 in q28 by repeated squaring, evaluated at elaboration
  function automatic longint log2_q28(input longint v);
    longint x;
    longint frac;
    int     e;
    e    = 0;
    frac = 0;
    for (int i = 0; i < 31; i++) begin
      if ((v >> (i + 1)) != 0) begin
        e = i + 1;
      end
    end
    x = v << (30 - e);
    for (int i = 0; i < LOG_STEPS; i++) begin
      x    = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (longint'(1) << 31)) begin
        x    = x >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << LOG_STEPS) + frac;
  endfunction

endpackage

### rtl/core/dpm_log_cell.sv
// one squaring step of the log2 fraction chain
// depends on dpm_pkg
`timescale 1ns / 1ps

module dpm_log_cell #(
  parameter int PW = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [dpm_pkg::LOG_XW-1:0]          in_x,
  input  logic [dpm_pkg::LOG_STEPS-1:0]       in_frac,
  input  logic [PW-1:0]                       in_pay,
  output logic                                out_valid,
  output logic [dpm_pkg::LOG_XW-1:0]          out_x,
  output logic [dpm_pkg::LOG_STEPS-1:0]       out_frac,
  output logic [PW-1:0]                       out_pay
);

  logic                              valid_r;
  logic [dpm_pkg::LOG_XW-1:0]        x_r, x_nxt;
  logic [dpm_pkg::LOG_STEPS-1:0]     frac_r, frac_nxt;
  logic [PW-1:0]                     pay_r;
  logic [2*dpm_pkg::LOG_XW-1:0]      sq;
  logic [dpm_pkg::LOG_XW:0]          y;

  always_comb begin
    sq = in_x * in_x;
    y  = sq[2*dpm_pkg::LOG_XW-1:30];
    if (y[dpm_pkg::LOG_XW]) begin
      x_nxt    = y[dpm_pkg::LOG_XW:1];
      frac_nxt = {in_frac[dpm_pkg::LOG_STEPS-2:0], 1'b1};
    end else begin
      x_nxt    = y[dpm_pkg::LOG_XW-1:0];
      frac_nxt = {in_frac[dpm_pkg::LOG_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      frac_r <= frac_nxt;
      pay_r  <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_frac  = frac_r;
  assign out_pay   = pay_r;

endmodule

### rtl/core/dpm_div_cell.sv
// one restoring division step, one quotient bit per cell
// no dependencies
`timescale 1ns / 1ps

module dpm_div_cell #(
  parameter int DW = 12,
  parameter int QW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_quo,
  input  logic [DW-1:0] in_dvs,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_dvs,
  output logic [PW-1:0] out_pay
);

  logic          valid_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r;
  logic [PW-1:0] pay_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial = {in_rem, in_quo[QW-1]};
    diff  = trial - {1'b0, in_dvs};
    if (trial >= {1'b0, in_dvs}) begin
      rem_nxt = diff[DW-1:0];
      quo_nxt = {in_quo[QW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DW-1:0];
      quo_nxt = {in_quo[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= in_dvs;
      pay_r <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_dvs   = dvs_r;
  assign out_pay   = pay_r;

endmodule

### rtl/core/dew_point_magnus_top.sv
// magnus dew point: one reading in, one dew point word out
// the path runs through the two divider cell rows and the 28-cell log2
// squaring row; one word accepted every cycle while the skid entry is empty
// a two-entry output stage keeps accepting while one result waits
// rst_n synchronous active low clears all valid flags; no clearing pass
// depends on dpm_pkg, dpm_log_cell, dpm_div_cell
`timescale 1ns / 1ps

module dew_point_magnus_top #(
  parameter int FRACTION_BITS = dpm_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // temperature_tenths, humidity_tenths
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // dew_point_tenths
  output logic        out_tuser   // invalid
);

  localparam int AW   = FRACTION_BITS + 5;
  localparam int GW   = AW + 2;
  localparam int NW1  = AW + 12;
  localparam int DW1  = 12;
  localparam int DW2  = AW + 1;
  localparam int QW2  = dpm_pkg::DEW_QW;
  localparam int U2W  = DW2 + QW2;
  localparam int N2W  = GW + 13;
  localparam int LS   = dpm_pkg::LOG_STEPS;
  localparam int XW   = dpm_pkg::LOG_XW;
  localparam int P1W  = 1 + 1 + XW + 4;
  localparam int PLW  = 1 + 4 + GW;
  localparam int P2W  = 3;
  localparam int RSH  = 58 - FRACTION_BITS;
  localparam longint AQ_L = ((longint'(17271) << FRACTION_BITS) + 500) / 1000;
  localparam logic [AW-1:0] AQ = AW'(AQ_L);
  localparam logic signed [32:0] L1000 = 33'(dpm_pkg::log2_q28(1000));
  localparam logic signed [63:0] RND = 64'sd1 <<< (RSH - 1);

  logic en;
  assign en = in_tready;

  // stage a
  logic signed [10:0]    t_in;
  logic [9:0]            h_in;
  logic signed [12:0]    dsum;
  logic [3:0]            e_in;
  logic                  a_valid_r;
  logic                  a_inv_r;
  logic signed [NW1-1:0] a_p_r, a_p_nxt;
  logic [DW1-1:0]        a_d_r;
  logic [XW-1:0]         a_x_r, a_x_nxt;
  logic [3:0]            a_e_r;

  assign t_in = $signed(in_tdata[10:0]);
  assign h_in = in_tdata[20:11];
  assign dsum = 13'sd2377 + {{2{t_in[10]}}, t_in};

  always_comb begin
    e_in = 4'd0;
    for (int i = 0; i < dpm_pkg::HUM_W; i++) begin
      if (h_in[i]) begin
        e_in = 4'(i);
      end
    end
    a_p_nxt = $signed({1'b0, AQ}) * t_in;
    a_x_nxt = XW'(h_in) << (5'd30 - {1'b0, e_in});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_inv_r <= (h_in == 10'd0);
      a_p_r   <= a_p_nxt;
      a_d_r   <= dsum[DW1-1:0];
      a_x_r   <= a_x_nxt;
      a_e_r   <= e_in;
    end
  end

  // stage b
  logic signed [NW1-1:0] m1;
  logic signed [NW1-1:0] d1x;
  logic [NW1-1:0]        b_u_r, b_u_nxt;
  logic                  b_valid_r;
  logic [DW1-1:0]        b_d_r;
  logic [P1W-1:0]        b_pay_r;

  assign d1x = $signed({{(NW1-DW1){1'b0}}, a_d_r});
  assign m1  = a_p_r + (d1x >>> 1);
  assign b_u_nxt = m1[NW1-1] ? NW1'(-m1 + d1x - 1) : NW1'(m1);

  always_ff @(posedge clk) begin
    if (en) begin
      b_u_r   <= b_u_nxt;
      b_d_r   <= a_d_r;
      b_pay_r <= {a_inv_r, m1[NW1-1], a_x_r, a_e_r};
    end
  end

  // term1 divider row
  logic [AW:0]           v1;
  logic [AW:0][DW1-1:0]  r1;
  logic [AW:0][AW-1:0]   q1;
  logic [AW:0][DW1-1:0]  s1;
  logic [AW:0][P1W-1:0]  p1;

  assign v1[0] = b_valid_r;
  assign r1[0] = b_u_r[NW1-1:AW];
  assign q1[0] = b_u_r[AW-1:0];
  assign s1[0] = b_d_r;
  assign p1[0] = b_pay_r;

  for (genvar g = 0; g < AW; g++) begin : g_div1
    dpm_div_cell #(.DW(DW1), .QW(AW), .PW(P1W)) u_cell (
      .clk, .rst_n, .en,
      .in_valid (v1[g]),   .in_rem (r1[g]),   .in_quo (q1[g]),
      .in_dvs   (s1[g]),   .in_pay (p1[g]),
      .out_valid(v1[g+1]), .out_rem(r1[g+1]), .out_quo(q1[g+1]),
      .out_dvs  (s1[g+1]), .out_pay(p1[g+1])
    );
  end

  // stage c
  logic signed [GW-1:0] qx1;
  logic                 c_valid_r;
  logic [XW-1:0]        c_x_r;
  logic [PLW-1:0]       c_pay_r;

  assign qx1 = $signed({2'b00, q1[AW]});

  always_ff @(posedge clk) begin
    if (en) begin
      c_x_r   <= p1[AW][XW+3:4];
      c_pay_r <= {p1[AW][P1W-1], p1[AW][3:0], p1[AW][P1W-2] ? -qx1 : qx1};
    end
  end

  // log2 squaring row
  logic [LS:0]            vl;
  logic [LS:0][XW-1:0]    xl;
  logic [LS:0][LS-1:0]    fl;
  logic [LS:0][PLW-1:0]   pl;

  assign vl[0] = c_valid_r;
  assign xl[0] = c_x_r;
  assign fl[0] = '0;
  assign pl[0] = c_pay_r;

  for (genvar g = 0; g < LS; g++) begin : g_log
    dpm_log_cell #(.PW(PLW)) u_cell (
      .clk, .rst_n, .en,
      .in_valid (vl[g]),   .in_x (xl[g]),   .in_frac (fl[g]),   .in_pay (pl[g]),
      .out_valid(vl[g+1]), .out_x(xl[g+1]), .out_frac(fl[g+1]), .out_pay(pl[g+1])
    );
  end

  // stages d through i
  logic                 d_valid_r, e_valid_r, f_valid_r, g_valid_r, h_valid_r, i_valid_r;
  logic                 d_inv_r, e_inv_r, f_inv_r, g_inv_r, h_inv_r;
  logic signed [GW-1:0] d_t1_r, e_t1_r, f_t1_r;
  logic signed [32:0]   d_diff_r;
  logic [45:0]          e_pl_r;
  logic signed [47:0]   e_ph_r;
  logic signed [63:0]   lsum;
  logic signed [GW-1:0] f_lnq_r;
  logic signed [GW-1:0] gam;
  logic signed [GW:0]   den;
  logic signed [GW-1:0] g_gam_r;
  logic [DW2-1:0]       g_den_r, h_den_r, i_den_r;
  logic                 g_dpos_r, h_dpos_r;
  logic signed [N2W-1:0] h_n2_r;
  logic signed [N2W-1:0] d2x;
  logic signed [N2W-1:0] m2;
  logic [U2W-1:0]       i_u_r;
  logic [P2W-1:0]       i_pay_r;

  assign lsum = ({{16{e_ph_r[47]}}, e_ph_r} <<< 16) + $signed({18'b0, e_pl_r}) + RND;
  assign gam  = f_t1_r + f_lnq_r;
  assign den  = $signed({{(GW+1-AW){1'b0}}, AQ}) - {gam[GW-1], gam};
  assign d2x  = $signed({{(N2W-DW2){1'b0}}, h_den_r});
  assign m2   = h_n2_r + (d2x >>> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      d_inv_r  <= pl[LS][PLW-1];
      d_t1_r   <= pl[LS][GW-1:0];
      d_diff_r <= $signed({1'b0, pl[LS][GW+3:GW], fl[LS]}) - L1000;
      e_inv_r  <= d_inv_r;
      e_t1_r   <= d_t1_r;
      e_pl_r   <= d_diff_r[15:0] * dpm_pkg::LN2_Q30;
      e_ph_r   <= $signed(d_diff_r[32:16]) * $signed({1'b0, dpm_pkg::LN2_Q30});
      f_inv_r  <= e_inv_r;
      f_t1_r   <= e_t1_r;
      f_lnq_r  <= GW'(lsum >>> RSH);
      g_inv_r  <= f_inv_r;
      g_gam_r  <= gam;
      g_den_r  <= den[DW2-1:0];
      g_dpos_r <= (den > 0);
      h_inv_r  <= g_inv_r;
      h_n2_r   <= g_gam_r * 14'sd2377;
      h_den_r  <= g_den_r;
      h_dpos_r <= g_dpos_r;
      i_u_r    <= m2[N2W-1] ? U2W'(-m2 + d2x - 1) : U2W'(m2);
      i_den_r  <= h_den_r;
      i_pay_r  <= {h_inv_r, h_dpos_r, m2[N2W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
      g_valid_r <= 1'b0;
      h_valid_r <= 1'b0;
      i_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_tvalid;
      b_valid_r <= a_valid_r;
      c_valid_r <= v1[AW];
      d_valid_r <= vl[LS];
      e_valid_r <= d_valid_r;
      f_valid_r <= e_valid_r;
      g_valid_r <= f_valid_r;
      h_valid_r <= g_valid_r;
      i_valid_r <= h_valid_r;
    end
  end

  // dew point divider row
  logic [QW2:0]           v2;
  logic [QW2:0][DW2-1:0]  r2;
  logic [QW2:0][QW2-1:0]  q2;
  logic [QW2:0][DW2-1:0]  s2;
  logic [QW2:0][P2W-1:0]  p2;

  assign v2[0] = i_valid_r;
  assign r2[0] = i_u_r[U2W-1:QW2];
  assign q2[0] = i_u_r[QW2-1:0];
  assign s2[0] = i_den_r;
  assign p2[0] = i_pay_r;

  for (genvar g = 0; g < QW2; g++) begin : g_div2
    dpm_div_cell #(.DW(DW2), .QW(QW2), .PW(P2W)) u_cell (
      .clk, .rst_n, .en,
      .in_valid (v2[g]),   .in_rem (r2[g]),   .in_quo (q2[g]),
      .in_dvs   (s2[g]),   .in_pay (p2[g]),
      .out_valid(v2[g+1]), .out_rem(r2[g+1]), .out_quo(q2[g+1]),
      .out_dvs  (s2[g+1]), .out_pay(p2[g+1])
    );
  end

  // final clamp
  logic signed [QW2:0]                 qs;
  logic signed [QW2:0]                 qv;
  logic signed [dpm_pkg::DEW_W-1:0]    dew;
  logic                                fin_inv;

  assign qs      = $signed({1'b0, q2[QW2]});
  assign qv      = p2[QW2][0] ? -qs : qs;
  assign fin_inv = p2[QW2][2];

  always_comb begin
    if (fin_inv) begin
      dew = '0;
    end else if (!p2[QW2][1] || qv > (QW2+1)'(dpm_pkg::DEW_HIGH)) begin
      dew = dpm_pkg::DEW_W'(dpm_pkg::DEW_HIGH);
    end else if (qv < (QW2+1)'(dpm_pkg::DEW_LOW)) begin
      dew = dpm_pkg::DEW_W'(dpm_pkg::DEW_LOW);
    end else begin
      dew = qv[dpm_pkg::DEW_W-1:0];
    end
  end

  // output register and skid
  logic                             out_valid_r, skid_valid_r;
  logic [dpm_pkg::DEW_W-1:0]        out_dew_r, skid_dew_r;
  logic                             out_inv_r, skid_inv_r;
  logic                             xfer;

  assign xfer      = v2[QW2] && en;
  assign in_tready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= xfer;
      end
    end else if (xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_dew_r <= skid_dew_r;
        out_inv_r <= skid_inv_r;
      end else begin
        out_dew_r <= dew;
        out_inv_r <= fin_inv;
      end
    end else if (xfer) begin
      skid_dew_r <= dew;
      skid_inv_r <= fin_inv;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_dew_r};
  assign out_tuser  = out_inv_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid word without output word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inv_r) |-> (out_dew_r == '0)) else $error("invalid word not zero");

  a_dew_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_dew_r) >= 11'(dpm_pkg::DEW_LOW)
                  && $signed(out_dew_r) <= 11'(dpm_pkg::DEW_HIGH)))
    else $error("dew point out of range");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid filled without stall");

endmodule
